@@ design/set_assoc_writeback_lru_cache_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative write-back cache
// Short forms for clocked implication checks used by the cache RTL.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_WRITEBACK_LRU_CACHE_MACROS_SVH
`define SET_ASSOC_WRITEBACK_LRU_CACHE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SAWLC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cache check failed");

// Next-cycle implication, disabled while reset is high.
`define SAWLC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cache check failed");

`endif

@@ design/sawlc_pkg.sv @@
// ----------------------------------------------------------------------------
// sawlc_pkg
// Shared constants and types of the set-associative write-back cache.
// ----------------------------------------------------------------------------
package sawlc_pkg;

   localparam int ADDR_W     = 32;
   localparam int CSR_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int OFFSET_MAX = 12;
   localparam int INDEX_CAP  = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BITS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_IN_USE = 2'd2;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef struct packed {
      logic              hit;
      logic              writeback_valid;
      logic [ADDR_W-1:0] writeback_address;
      logic              fill_valid;
      logic [ADDR_W-1:0] fill_address;
   } rsp_type;

endpackage

@@ design/sawlc_tag_ram.sv @@
// ----------------------------------------------------------------------------
// sawlc_tag_ram
// One-port-read, one-port-write synchronous RAM holding one cache set per row.
// ----------------------------------------------------------------------------
module sawlc_tag_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 296,
   parameter int ADDR_BITS = 8
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/sawlc_lookup.sv @@
// ----------------------------------------------------------------------------
// sawlc_lookup
// Tag compare, victim choice and LRU rank update for one set.
// ----------------------------------------------------------------------------
module sawlc_lookup
   import sawlc_pkg::*;
#(
   parameter int WAYS   = 8,
   parameter int SET_W  = 8,
   parameter int WAY_W  = 3,
   parameter int RANK_W = 3,
   parameter int NWAY_W = 4
) (
   input  logic                          row_init,
   input  logic [WAYS-1:0][ADDR_W-1:0]   old_tag,
   input  logic [WAYS-1:0]               old_valid,
   input  logic [WAYS-1:0]               old_dirty,
   input  logic [WAYS-1:0][RANK_W-1:0]   old_rank,
   input  logic                          command,
   input  logic [ADDR_W-1:0]             address,
   input  logic [ADDR_W-1:0]             tag,
   input  logic [SET_W-1:0]              set_idx,
   input  logic [3:0]                    off_bits,
   input  logic [3:0]                    idx_bits,
   input  logic [NWAY_W-1:0]             nways,
   output logic [WAYS-1:0][ADDR_W-1:0]   new_tag,
   output logic [WAYS-1:0]               new_valid,
   output logic [WAYS-1:0]               new_dirty,
   output logic [WAYS-1:0][RANK_W-1:0]   new_rank,
   output rsp_type                       rsp
);

   logic [WAYS-1:0]             cur_valid;
   logic [WAYS-1:0]             cur_dirty;
   logic [WAYS-1:0][RANK_W-1:0] cur_rank;

   // A row never written since reset reads as all invalid with ranks in way order.
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         cur_valid[w] = row_init & old_valid[w];
         cur_dirty[w] = row_init & old_dirty[w];
         cur_rank[w]  = row_init ? old_rank[w] : RANK_W'(w);
      end
   end

   always_comb begin
      logic              found;
      logic [WAY_W-1:0]  hit_way;
      logic [WAY_W-1:0]  victim;
      logic [RANK_W-1:0] victim_rank;
      logic [WAY_W-1:0]  used;
      logic [RANK_W-1:0] used_rank;
      logic [ADDR_W-1:0] wb_addr;

      found   = 1'b0;
      hit_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!found && (NWAY_W'(w) < nways) && cur_valid[w] && (old_tag[w] == tag)) begin
            found   = 1'b1;
            hit_way = WAY_W'(w);
         end
      end

      // Largest rank wins; strict compare keeps the lowest way on a tie.
      victim      = '0;
      victim_rank = cur_rank[0];
      for (int w = 1; w < WAYS; w++) begin
         if ((NWAY_W'(w) < nways) && (cur_rank[w] > victim_rank)) begin
            victim      = WAY_W'(w);
            victim_rank = cur_rank[w];
         end
      end

      used      = found ? hit_way : victim;
      used_rank = cur_rank[used];

      new_tag   = old_tag;
      new_valid = cur_valid;
      new_dirty = cur_dirty;
      for (int w = 0; w < WAYS; w++) begin
         if (WAY_W'(w) == used) begin
            new_rank[w] = '0;
         end else if ((NWAY_W'(w) < nways) && (cur_rank[w] < used_rank)) begin
            new_rank[w] = cur_rank[w] + RANK_W'(1);
         end else begin
            new_rank[w] = cur_rank[w];
         end
      end

      wb_addr = ((old_tag[victim] << idx_bits) | ADDR_W'(set_idx)) << off_bits;

      if (found) begin
         if (command == CMD_WRITE) begin
            new_dirty[hit_way] = 1'b1;
         end
         rsp.hit               = 1'b1;
         rsp.writeback_valid   = 1'b0;
         rsp.writeback_address = '0;
         rsp.fill_valid        = 1'b0;
         rsp.fill_address      = '0;
      end else begin
         new_tag[victim]       = tag;
         new_valid[victim]     = 1'b1;
         new_dirty[victim]     = (command == CMD_WRITE);
         rsp.hit               = 1'b0;
         rsp.writeback_valid   = cur_valid[victim] & cur_dirty[victim];
         rsp.writeback_address = (cur_valid[victim] & cur_dirty[victim]) ? wb_addr : '0;
         rsp.fill_valid        = 1'b1;
         rsp.fill_address      = address & ~((ADDR_W'(1) << off_bits) - ADDR_W'(1));
      end
   end

endmodule

@@ design/set_assoc_writeback_lru_cache.sv @@
// ----------------------------------------------------------------------------
// set_assoc_writeback_lru_cache
// Tag and state controller of a write-back, write-allocate cache with true LRU.
// ----------------------------------------------------------------------------
// Usage:
// A request (req_command, req_address) is taken at a rising edge where start
// is high and busy is low. The set row is read from the tag RAM at that edge;
// in the following cycle busy is high while the row is compared, the victim
// chosen, the LRU ranks updated and the row written back. At the end of that
// cycle the result is registered and shown for exactly one cycle with
// rsp_strobe high. The receiver cannot stall, so results are never held.
// The strobe follows accept through busy_ff and the result register. No new
// request is taken while busy is high, as the read-modify-write of the single
// set row uses the RAM's registered read port. The next request may be
// accepted in the cycle the previous result is shown, since its write-back
// has already landed, so no forwarding is needed.
// The csr_ port writes the geometry registers at any edge with csr_write high;
// it is meant to be used only while the block is idle.
// Reset restores the register defaults and clears one flip-flop per set, which
// makes every set read as invalid, clean and with ranks in way order. There is
// no clearing pass, so requests are accepted right after reset.
// ----------------------------------------------------------------------------
`include "set_assoc_writeback_lru_cache_macros.svh"

module set_assoc_writeback_lru_cache
   import sawlc_pkg::*;
#(
   parameter int MAX_SETS = 256,
   parameter int WAYS     = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_command,
   input  logic [ADDR_W-1:0]    req_address,
   output logic                 rsp_strobe,
   output logic                 rsp_hit,
   output logic                 rsp_writeback_valid,
   output logic [ADDR_W-1:0]    rsp_writeback_address,
   output logic                 rsp_fill_valid,
   output logic [ADDR_W-1:0]    rsp_fill_address,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RANK_W   = WAY_W;
   localparam int NWAY_W   = $clog2(WAYS + 1);
   localparam int SET_LOG  = $clog2(MAX_SETS + 1) - 1;
   localparam int IDX_MAX  = (SET_LOG < INDEX_CAP) ? SET_LOG : INDEX_CAP;
   localparam int ROW_W    = WAYS * (ADDR_W + 2 + RANK_W);

   // Geometry registers.
   logic [CSR_W-1:0] offset_cfg_ff, offset_cfg_in;
   logic [CSR_W-1:0] index_cfg_ff,  index_cfg_in;
   logic [CSR_W-1:0] ways_cfg_ff,   ways_cfg_in;

   always_comb begin
      offset_cfg_in = offset_cfg_ff;
      index_cfg_in  = index_cfg_ff;
      ways_cfg_in   = ways_cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_OFFSET_BITS: offset_cfg_in = csr_data;
            CSR_INDEX_BITS:  index_cfg_in  = csr_data;
            CSR_WAYS_IN_USE: ways_cfg_in   = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_cfg_ff <= 4'd5;
         index_cfg_ff  <= 4'd6;
         ways_cfg_ff   <= 4'd4;
      end else begin
         offset_cfg_ff <= offset_cfg_in;
         index_cfg_ff  <= index_cfg_in;
         ways_cfg_ff   <= ways_cfg_in;
      end
   end

   // Effective geometry: out-of-range register values are clamped.
   logic [3:0]        eff_off;
   logic [3:0]        eff_idx;
   logic [NWAY_W-1:0] eff_ways;

   always_comb begin
      eff_off = (32'(offset_cfg_ff) > OFFSET_MAX) ? 4'(OFFSET_MAX) : offset_cfg_ff;
      eff_idx = (32'(index_cfg_ff) > IDX_MAX) ? 4'(IDX_MAX) : index_cfg_ff;
      if (ways_cfg_ff == 4'd0) begin
         eff_ways = NWAY_W'(1);
      end else if (32'(ways_cfg_ff) > WAYS) begin
         eff_ways = NWAY_W'(WAYS);
      end else begin
         eff_ways = NWAY_W'(ways_cfg_ff);
      end
   end

   // Address split of the incoming request.
   logic              accept;
   logic [ADDR_W-1:0] req_set_full;
   logic [SET_W-1:0]  req_set;
   logic [ADDR_W-1:0] req_tag;

   assign accept       = start & ~busy;
   assign req_set_full = (req_address >> eff_off) & ((ADDR_W'(1) << eff_idx) - ADDR_W'(1));
   assign req_set      = req_set_full[SET_W-1:0];
   assign req_tag      = req_address >> (5'(eff_off) + 5'(eff_idx));

   // Lookup stage registers, loaded on accept.
   logic              busy_ff, busy_in;
   logic              cmd_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] tag_ff;
   logic [SET_W-1:0]  set_ff;
   logic [3:0]        off_ff;
   logic [3:0]        idx_ff;
   logic [NWAY_W-1:0] ways_ff;
   logic              row_init_rd_ff;

   // One flag per set: the row has been written since reset.
   logic [MAX_SETS-1:0] row_init_ff, row_init_in;

   assign busy_in = accept;

   always_comb begin
      row_init_in = row_init_ff;
      if (busy_ff) begin
         row_init_in[set_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         row_init_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         row_init_ff <= row_init_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff         <= req_command;
         addr_ff        <= req_address;
         tag_ff         <= req_tag;
         set_ff         <= req_set;
         off_ff         <= eff_off;
         idx_ff         <= eff_idx;
         ways_ff        <= eff_ways;
         row_init_rd_ff <= row_init_ff[req_set];
      end
   end

   assign busy = busy_ff;

   // Set row storage: tags, valid, dirty and ranks of every way.
   logic [ROW_W-1:0] rd_row;
   logic [ROW_W-1:0] wr_row;

   sawlc_tag_ram #(
      .DEPTH     (MAX_SETS),
      .WIDTH     (ROW_W),
      .ADDR_BITS (SET_W)
   ) u_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (rd_row),
      .wr_en   (busy_ff),
      .wr_addr (set_ff),
      .wr_data (wr_row)
   );

   logic [WAYS-1:0][ADDR_W-1:0] old_tag,   new_tag;
   logic [WAYS-1:0]             old_valid, new_valid;
   logic [WAYS-1:0]             old_dirty, new_dirty;
   logic [WAYS-1:0][RANK_W-1:0] old_rank,  new_rank;
   rsp_type                     lookup_rsp;

   assign {old_tag, old_valid, old_dirty, old_rank} = rd_row;
   assign wr_row = {new_tag, new_valid, new_dirty, new_rank};

   sawlc_lookup #(
      .WAYS   (WAYS),
      .SET_W  (SET_W),
      .WAY_W  (WAY_W),
      .RANK_W (RANK_W),
      .NWAY_W (NWAY_W)
   ) u_lookup (
      .row_init  (row_init_rd_ff),
      .old_tag   (old_tag),
      .old_valid (old_valid),
      .old_dirty (old_dirty),
      .old_rank  (old_rank),
      .command   (cmd_ff),
      .address   (addr_ff),
      .tag       (tag_ff),
      .set_idx   (set_ff),
      .off_bits  (off_ff),
      .idx_bits  (idx_ff),
      .nways     (ways_ff),
      .new_tag   (new_tag),
      .new_valid (new_valid),
      .new_dirty (new_dirty),
      .new_rank  (new_rank),
      .rsp       (lookup_rsp)
   );

   // Result register: the strobe lasts one cycle, the payload holds until the next.
   logic    strobe_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         rsp_ff <= lookup_rsp;
      end
   end

   assign rsp_strobe            = strobe_ff;
   assign rsp_hit               = rsp_ff.hit;
   assign rsp_writeback_valid   = rsp_ff.writeback_valid;
   assign rsp_writeback_address = rsp_ff.writeback_address;
   assign rsp_fill_valid        = rsp_ff.fill_valid;
   assign rsp_fill_address      = rsp_ff.fill_address;

   // Every lookup cycle produces a result in the next cycle.
   `SAWLC_ASSERT_NEXT(a_lookup_gives_result, busy_ff, strobe_ff)
   // No request is accepted while busy is high, so busy falls again after each lookup.
   `SAWLC_ASSERT_NEXT(a_busy_one_cycle, busy_ff, !busy_ff)
   // A hit never requests a fill or a writeback.
   `SAWLC_ASSERT_SAME(a_hit_no_traffic, strobe_ff && rsp_ff.hit,
                      !rsp_ff.fill_valid && !rsp_ff.writeback_valid)
   // A writeback only happens together with a fill.
   `SAWLC_ASSERT_SAME(a_writeback_with_fill, strobe_ff && rsp_ff.writeback_valid,
                      rsp_ff.fill_valid)

endmodule
